### rtl/srse_pkg.sv
`default_nettype none

package srse_pkg;

   // row geometry
   localparam int WORDS_PER_ROW = 16;
   localparam int COL_W         = 4;
   localparam int ROW_W         = 5;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(WORDS_PER_ROW - 1);

   // segment data store
   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   localparam int BYTE_W     = 8;
   localparam int GAP_W      = 4;
   localparam int WORD_BYTES = 2;
   localparam int HDR_BYTES  = 3;

   localparam logic [GAP_W-1:0]  MAX_GAP_RESET = GAP_W'(2);
   localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

   // header byte positions within a segment
   localparam logic [CNT_W-1:0] EMIT_ROW = CNT_W'(0);
   localparam logic [CNT_W-1:0] EMIT_COL = CNT_W'(1);
   localparam logic [CNT_W-1:0] EMIT_LEN = CNT_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_EMIT
   } state_type;

   // one byte slot handed from the sequencer to the output queue
   typedef struct packed {
      logic              vld;
      logic              from_ram;
      logic [BYTE_W-1:0] hdr_byte;
      logic              last;
   } emit_issue_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

endpackage

`default_nettype wire

### rtl/srse_ifs.sv
`default_nettype none

interface srse_req_if import srse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [BYTE_W-1:0] first_byte;
   logic [BYTE_W-1:0] second_byte;
   logic [COL_W-1:0]  word_column;
   logic [ROW_W-1:0]  word_row;

   modport source (output valid, first_byte, second_byte, word_column, word_row,
                   input ready);
   modport sink   (input valid, first_byte, second_byte, word_column, word_row,
                   output ready);
endinterface

interface srse_rsp_if import srse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              segment_end;

   modport source (output valid, out_byte, segment_end, input ready);
   modport sink   (input valid, out_byte, segment_end, output ready);
endinterface

interface srse_csr_if import srse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [GAP_W-1:0] max_gap;

   modport source (output valid, max_gap, input ready);
   modport sink   (input valid, max_gap, output ready);
endinterface

`default_nettype wire

### rtl/srse_ram.sv
`default_nettype none

module srse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/srse_ctrl.sv
`default_nettype none

module srse_ctrl import srse_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [BYTE_W-1:0] in_first,
   input  wire logic [BYTE_W-1:0] in_second,
   input  wire logic [COL_W-1:0]  in_col,
   input  wire logic [ROW_W-1:0]  in_row,
   input  wire logic [GAP_W-1:0]  max_gap,
   input  wire logic              slot_free,
   output emit_issue_type         issue,
   output ram_wr_type             wr,
   output ram_rd_type             rd
);

   state_type         state_ff, state_in;
   logic              in_seg_ff, in_seg_in;
   logic [GAP_W-1:0]  pend_ff, pend_in;
   logic [ROW_W-1:0]  srow_ff, srow_in;
   logic [COL_W-1:0]  scol_ff, scol_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  fleft_ff, fleft_in;
   logic [CNT_W-1:0]  eidx_ff, eidx_in;
   logic [BYTE_W-1:0] b0_ff, b0_in;
   logic [BYTE_W-1:0] b1_ff, b1_in;
   logic              rend_ff, rend_in;

   logic accept, zero_word, row_end, close_now, fill_last, emit_last, store_room;

   assign accept     = in_valid && (state_ff == ST_IDLE);
   assign zero_word  = (in_first == ZERO_BYTE) && (in_second == ZERO_BYTE);
   assign row_end    = (in_col == LAST_COL);
   assign close_now  = in_seg_ff && ((pend_ff >= max_gap) || row_end);
   assign fill_last  = (fleft_ff == CNT_W'(1));
   assign emit_last  = (eidx_ff == cnt_ff + CNT_W'(HDR_BYTES - 1));
   assign store_room = (cnt_ff < CNT_W'(STORE_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!zero_word) begin
                  state_in = ST_FILL;
               end else if (close_now) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = rend_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      in_ready       = (state_ff == ST_IDLE);
      wr.en          = (state_ff == ST_FILL) && store_room;
      wr.addr        = cnt_ff[ADDR_W-1:0];
      if (fleft_ff == CNT_W'(WORD_BYTES)) begin
         wr.data = b0_ff;
      end else if (fill_last) begin
         wr.data = b1_ff;
      end else begin
         wr.data = ZERO_BYTE;
      end
      issue.vld      = (state_ff == ST_EMIT) && slot_free;
      issue.from_ram = (eidx_ff >= CNT_W'(HDR_BYTES));
      issue.last     = emit_last;
      if (eidx_ff == EMIT_ROW) begin
         issue.hdr_byte = BYTE_W'(srow_ff);
      end else if (eidx_ff == EMIT_COL) begin
         issue.hdr_byte = BYTE_W'(scol_ff);
      end else if (eidx_ff == EMIT_LEN) begin
         issue.hdr_byte = BYTE_W'(cnt_ff);
      end else begin
         issue.hdr_byte = ZERO_BYTE;
      end
      rd.en   = issue.vld && issue.from_ram;
      rd.addr = ADDR_W'(eidx_ff - CNT_W'(HDR_BYTES));
   end

   // datapath next values
   always_comb begin
      in_seg_in = in_seg_ff;
      pend_in   = pend_ff;
      srow_in   = srow_ff;
      scol_in   = scol_ff;
      cnt_in    = cnt_ff;
      fleft_in  = fleft_ff;
      eidx_in   = eidx_ff;
      b0_in     = b0_ff;
      b1_in     = b1_ff;
      rend_in   = rend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               b0_in   = in_first;
               b1_in   = in_second;
               rend_in = row_end;
               if (zero_word) begin
                  if (close_now) begin
                     in_seg_in = 1'b0;
                     pend_in   = '0;
                     eidx_in   = '0;
                  end else if (in_seg_ff) begin
                     pend_in = pend_ff + GAP_W'(1);
                  end
               end else begin
                  if (in_seg_ff) begin
                     // bridged zero words go in ahead of the new data
                     fleft_in = CNT_W'({pend_ff, 1'b0}) + CNT_W'(WORD_BYTES);
                  end else begin
                     srow_in  = in_row;
                     scol_in  = in_col;
                     cnt_in   = '0;
                     fleft_in = CNT_W'(WORD_BYTES);
                  end
                  in_seg_in = 1'b1;
                  pend_in   = '0;
               end
            end
         end
         ST_FILL: begin
            fleft_in = fleft_ff - CNT_W'(1);
            if (store_room) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (fill_last && rend_ff) begin
               in_seg_in = 1'b0;
               pend_in   = '0;
               eidx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               eidx_in = eidx_ff + CNT_W'(1);
               if (emit_last) begin
                  cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_seg_ff <= 1'b0;
         pend_ff   <= '0;
         srow_ff   <= '0;
         scol_ff   <= '0;
         cnt_ff    <= '0;
         fleft_ff  <= '0;
         eidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         in_seg_ff <= in_seg_in;
         pend_ff   <= pend_in;
         srow_ff   <= srow_in;
         scol_ff   <= scol_in;
         cnt_ff    <= cnt_in;
         fleft_ff  <= fleft_in;
         eidx_ff   <= eidx_in;
      end
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      rend_ff <= rend_in;
   end

endmodule

`default_nettype wire

### rtl/srse_outq.sv
`default_nettype none

module srse_outq import srse_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire emit_issue_type    issue,
   input  wire logic [BYTE_W-1:0] ram_data,
   output logic                   slot_free,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [BYTE_W-1:0]      out_byte,
   output logic                   out_end
);

   // stage 1 waits for the RAM read; RAM output holds while no read is issued
   logic              s1_vld_ff, s1_vld_in;
   logic              s1_ram_ff, s1_ram_in;
   logic [BYTE_W-1:0] s1_hdr_ff, s1_hdr_in;
   logic              s1_last_ff, s1_last_in;
   logic              ov_ff, ov_in;
   logic [BYTE_W-1:0] ob_ff, ob_in;
   logic              oe_ff, oe_in;
   logic              s1_take;

   assign s1_take   = s1_vld_ff && (!ov_ff || out_ready);
   assign slot_free = !s1_vld_ff || s1_take;

   always_comb begin
      s1_vld_in  = issue.vld || (s1_vld_ff && !s1_take);
      s1_ram_in  = issue.vld ? issue.from_ram : s1_ram_ff;
      s1_hdr_in  = issue.vld ? issue.hdr_byte : s1_hdr_ff;
      s1_last_in = issue.vld ? issue.last     : s1_last_ff;
      ov_in      = s1_take || (ov_ff && !out_ready);
      ob_in      = ob_ff;
      oe_in      = oe_ff;
      if (s1_take) begin
         ob_in = s1_ram_ff ? ram_data : s1_hdr_ff;
         oe_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         ov_ff     <= ov_in;
      end
      s1_ram_ff  <= s1_ram_in;
      s1_hdr_ff  <= s1_hdr_in;
      s1_last_ff <= s1_last_in;
      ob_ff      <= ob_in;
      oe_ff      <= oe_in;
   end

   assign out_valid = ov_ff;
   assign out_byte  = ob_ff;
   assign out_end   = oe_ff;

endmodule

`default_nettype wire

### rtl/sparse_row_segment_encoder.sv
// Sparse row segment encoder.
// req (sink): one 16-bit display word per transfer, two pixel bytes plus its
//   column and row. Words arrive in row order; the last column closes the row.
// rsp (source): one encoded byte per transfer: row, column, length, then the
//   stored data bytes of a segment; segment_end marks its last byte.
// csr (sink): writes max_gap, the zero words bridged inside a segment. Always
//   ready; write only while the block is idle. Reset value 2.
// Flow: an accepted word that stores data holds req.ready low while its 2*z+2
//   bytes are written, z being the bridged zero words written ahead of it (one byte per
//   cycle through the single write port of the 32-byte segment store). A
//   plain zero word that does not close leaves req ready. A closing word then streams 3+n bytes,
//   one per cycle while rsp.ready allows, through the store's read port and a
//   two-deep output queue; req stays blocked until the last byte has been
//   issued.
// Stall: a low rsp.ready freezes the output register and, once the queue is
//   full, the segment readout; nothing is lost or repeated.
// Reset: synchronous, active high; clears the open segment, empties the
//   output queue and loads max_gap with 2. The store needs no clearing pass.
`default_nettype none

module sparse_row_segment_encoder import srse_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   srse_req_if.sink   req,
   srse_rsp_if.source rsp,
   srse_csr_if.sink   csr
);

   logic [GAP_W-1:0]  max_gap_ff, max_gap_in;
   logic              slot_free;
   emit_issue_type    issue;
   ram_wr_type        wr;
   ram_rd_type        rd;
   logic [BYTE_W-1:0] ram_data;

   // configuration register
   assign csr.ready  = 1'b1;
   assign max_gap_in = (csr.valid) ? csr.max_gap : max_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= MAX_GAP_RESET;
      end else begin
         max_gap_ff <= max_gap_in;
      end
   end

   // segment sequencer: fill from words, read out on close
   srse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_first  (req.first_byte),
      .in_second (req.second_byte),
      .in_col    (req.word_column),
      .in_row    (req.word_row),
      .max_gap   (max_gap_ff),
      .slot_free (slot_free),
      .issue     (issue),
      .wr        (wr),
      .rd        (rd)
   );

   // segment data store
   srse_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (ram_data)
   );

   // read stage and output register
   srse_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .ram_data  (ram_data),
      .slot_free (slot_free),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_byte  (rsp.out_byte),
      .out_end   (rsp.segment_end)
   );

endmodule

`default_nettype wire

### rtl/srse_chk.sv
`default_nettype none

module srse_chk import srse_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [BYTE_W-1:0] req_first_byte,
   input wire logic [BYTE_W-1:0] req_second_byte,
   input wire logic [COL_W-1:0]  req_word_column,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_out_byte,
   input wire logic              rsp_segment_end
);

   // reset leaves the block empty and ready for a word
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   // a data word at the last column must be stored and flushed: input blocks
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_word_column == LAST_COL) &&
       ((req_first_byte != ZERO_BYTE) || (req_second_byte != ZERO_BYTE)))
      |=> !req_ready)
      else $error("row end with data did not block input");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      ($stable(rsp_out_byte) && $stable(rsp_segment_end)))
      else $error("rsp word changed while stalled");

endmodule

bind sparse_row_segment_encoder srse_chk u_srse_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_first_byte  (req.first_byte),
   .req_second_byte (req.second_byte),
   .req_word_column (req.word_column),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_byte    (rsp.out_byte),
   .rsp_segment_end (rsp.segment_end)
);

`default_nettype wire
